// ===== hdl/htfd_pkg.sv =====
// Shared types, constants and the CRC-8 helper for the humidity/temperature frame decoder.
// No dependencies; imported by the front end, queue, back end and top level.
package htfd_pkg;

    // CRC-8, polynomial x^8+x^5+x^4+1, MSB first, no final XOR
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // byte positions inside a frame
    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // decoupling queue between byte assembly and conversion
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // conversion: raw * scale / 65535, raw is 16 bits, scale up to 18 bits
    localparam int         PROD_W      = 34;
    localparam logic [17:0] TEMP_SCALE = 18'd175000;
    localparam logic [17:0] HUM_SCALE  = 18'd100000;
    localparam logic [16:0] DIV_CONST  = 17'd65535;
    localparam logic signed [18:0] TEMP_OFFSET = 19'sd45000;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
        logic        crc_ok;
    } frame_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/htfd_front.sv =====
// Front end: counts byte positions, assembles the raw words and checks both CRCs.
// Depends on htfd_pkg; pushes one frame_t per completed frame into htfd_queue.
module htfd_front
    import htfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       frame_start,
    output logic       frame_push,
    output frame_t     frame_data
);

    logic [2:0]  pos_reg;
    logic [7:0]  crc_reg;
    logic [15:0] temp_word_reg;
    logic [15:0] hum_word_reg;
    logic        first_good_reg;

    logic [2:0]  pos_eff;
    logic [7:0]  crc_seed;
    logic [7:0]  crc_new;

    // a start flag or a stray position restarts the frame
    assign pos_eff  = (frame_start || pos_reg > POS_H_CRC) ? POS_T_MSB : pos_reg;
    assign crc_seed = (pos_eff == POS_T_MSB || pos_eff == POS_H_MSB) ? CRC_INIT : crc_reg;
    assign crc_new  = crc8_byte(crc_seed, data_byte);

    assign frame_push          = accept && (pos_eff == POS_H_CRC);
    assign frame_data.temp_raw = temp_word_reg;
    assign frame_data.hum_raw  = hum_word_reg;
    assign frame_data.crc_ok   = first_good_reg && (crc_reg == data_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= POS_T_MSB;
            crc_reg        <= CRC_INIT;
            temp_word_reg  <= '0;
            hum_word_reg   <= '0;
            first_good_reg <= 1'b0;
        end
        else if (accept)
        begin
            // last byte of a frame wraps the position back to the start
            pos_reg <= (pos_eff == POS_H_CRC) ? POS_T_MSB : pos_eff + 3'd1;
            case (pos_eff)
                POS_T_MSB:
                begin
                    temp_word_reg <= {data_byte, 8'h00};
                    crc_reg       <= crc_new;
                end
                POS_T_LSB:
                begin
                    temp_word_reg <= {temp_word_reg[15:8], data_byte};
                    crc_reg       <= crc_new;
                end
                POS_T_CRC:
                begin
                    first_good_reg <= (crc_reg == data_byte);
                    crc_reg        <= CRC_INIT;
                end
                POS_H_MSB:
                begin
                    hum_word_reg <= {data_byte, 8'h00};
                    crc_reg      <= crc_new;
                end
                POS_H_LSB:
                begin
                    hum_word_reg <= {hum_word_reg[15:8], data_byte};
                    crc_reg      <= crc_new;
                end
                default:
                begin
                    crc_reg <= CRC_INIT;
                end
            endcase
        end
    end

endmodule

// ===== hdl/htfd_queue.sv =====
// Short flop-based queue of completed frames between front end and converter.
// Depends on htfd_pkg for frame_t and the queue depth.
module htfd_queue
    import htfd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  frame_t wr_data,
    input  logic   rd_en,
    output logic   full,
    output logic   has_data,
    output frame_t rd_data
);

    frame_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    logic do_wr;
    logic do_rd;

    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign has_data = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && has_data;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!do_wr && do_rd)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/htfd_back.sv =====
// Back end: scales the raw words and divides by 65535 in a three-stage pipeline
// ending in the output register. Depends on htfd_pkg; fed from htfd_queue.
module htfd_back
    import htfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  frame_t             in_data,
    output logic               in_take,
    input  logic               pop,
    output logic               empty,
    output logic signed [17:0] temperature_milli_c,
    output logic [16:0]        humidity_milli_pct,
    output logic               check_status
);

    // stage 1: products
    logic              s1_valid_reg;
    logic [PROD_W-1:0] s1_tprod_reg;
    logic [PROD_W-1:0] s1_hprod_reg;
    logic              s1_ok_reg;
    // stage 2: first fold of p = hi*65535 + (hi + lo)
    logic              s2_valid_reg;
    logic [17:0]       s2_thi_reg;
    logic [17:0]       s2_trem_reg;
    logic [17:0]       s2_hhi_reg;
    logic [17:0]       s2_hrem_reg;
    logic              s2_ok_reg;
    // output register
    logic               out_valid_reg;
    logic signed [17:0] temp_reg;
    logic [16:0]        hum_reg;
    logic               status_reg;

    logic out_free;
    logic s2_go;
    logic s1_go;
    logic [17:0]        t_quot;
    logic [17:0]        h_quot;
    logic signed [18:0] t_signed;

    function automatic logic [17:0] fold_rem(input logic [PROD_W-1:0] p);
        return 18'(p[15:0]) + p[PROD_W-1:16];
    endfunction

    // rem < 4*65536, so a second fold leaves less than 2*65535: one compare finishes
    function automatic logic [17:0] finish_quot(input logic [17:0] hi, input logic [17:0] rem);
        logic [16:0] rem2;
        logic        adj;
        rem2 = 17'(rem[15:0]) + 17'(rem[17:16]);
        adj  = (rem2 >= DIV_CONST);
        return hi + 18'(rem[17:16]) + 18'(adj);
    endfunction

    assign out_free = !out_valid_reg || pop;
    assign s2_go    = !s2_valid_reg || out_free;
    assign s1_go    = !s1_valid_reg || s2_go;
    assign in_take  = in_valid && s1_go;

    assign t_quot   = finish_quot(s2_thi_reg, s2_trem_reg);
    assign h_quot   = finish_quot(s2_hhi_reg, s2_hrem_reg);
    assign t_signed = $signed({1'b0, t_quot}) - TEMP_OFFSET;

    assign empty               = !out_valid_reg;
    assign temperature_milli_c = temp_reg;
    assign humidity_milli_pct  = hum_reg;
    assign check_status        = status_reg;

    always_ff @(posedge clk)
    begin
        if (s1_go && in_valid)
        begin
            s1_tprod_reg <= PROD_W'(in_data.temp_raw) * PROD_W'(TEMP_SCALE);
            s1_hprod_reg <= PROD_W'(in_data.hum_raw) * PROD_W'(HUM_SCALE);
            s1_ok_reg    <= in_data.crc_ok;
        end
        if (s2_go && s1_valid_reg)
        begin
            s2_thi_reg  <= s1_tprod_reg[PROD_W-1:16];
            s2_trem_reg <= fold_rem(s1_tprod_reg);
            s2_hhi_reg  <= s1_hprod_reg[PROD_W-1:16];
            s2_hrem_reg <= fold_rem(s1_hprod_reg);
            s2_ok_reg   <= s1_ok_reg;
        end
        if (out_free && s2_valid_reg)
        begin
            if (s2_ok_reg)
            begin
                temp_reg   <= t_signed[17:0];
                hum_reg    <= h_quot[16:0];
                status_reg <= STATUS_OK;
            end
            else
            begin
                temp_reg   <= '0;
                hum_reg    <= '0;
                status_reg <= STATUS_BAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_go)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_go)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

endmodule

// ===== hdl/humidity_temp_frame_decoder_top.sv =====
// Top level of the humidity/temperature frame decoder.
// Depends on htfd_pkg, htfd_front, htfd_queue and htfd_back.

// Takes one sensor byte per item (temperature MSB, LSB, CRC, humidity MSB,
// LSB, CRC) and after the sixth byte of a frame produces one result: the
// temperature in millidegrees C, the relative humidity in milli-percent and a
// status bit that is 1, with both values zero, when either CRC-8 (poly 0x31,
// init 0xFF) fails. frame_start restarts the byte count and drops a partial
// frame. One byte is accepted every clock while full is low; each result
// passes through the frame queue, then the multiply, fold and correct stages
// of the converter. A two-entry frame queue separates byte assembly from
// conversion, so full only rises once two finished frames and the converter
// pipeline all wait behind a stalled result side.
module humidity_temp_frame_decoder_top
    import htfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         data_byte,
    input  logic               frame_start,
    output logic               empty,
    input  logic               pop,
    output logic signed [17:0] temperature_milli_c,
    output logic [16:0]        humidity_milli_pct,
    output logic               check_status
);

    logic   accept;
    logic   frame_push;
    frame_t frame_in;
    frame_t frame_out;
    logic   q_has_data;
    logic   q_take;

    assign accept = push && !full;

    htfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .frame_push  (frame_push),
        .frame_data  (frame_in)
    );

    htfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (frame_push),
        .wr_data  (frame_in),
        .rd_en    (q_take),
        .full     (full),
        .has_data (q_has_data),
        .rd_data  (frame_out)
    );

    htfd_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (q_has_data),
        .in_data             (frame_out),
        .in_take             (q_take),
        .pop                 (pop),
        .empty               (empty),
        .temperature_milli_c (temperature_milli_c),
        .humidity_milli_pct  (humidity_milli_pct),
        .check_status        (check_status)
    );

endmodule

// ===== hdl/htfd_checker.sv =====
// Port-level checks for the humidity/temperature frame decoder, bound to its top level.
// Depends on nothing but the top level's ports.
module htfd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic [7:0]         data_byte,
    input logic               frame_start,
    input logic               empty,
    input logic               pop,
    input logic signed [17:0] temperature_milli_c,
    input logic [16:0]        humidity_milli_pct,
    input logic               check_status
);

    // a waiting result stays put until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(temperature_milli_c)
            && $stable(humidity_milli_pct) && $stable(check_status)))
        else $error("waiting result changed before pop");

    // failed checksum gives zero values
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && check_status) |-> (temperature_milli_c == 18'sd0
            && humidity_milli_pct == 17'd0))
        else $error("checksum failure with nonzero values");

    // good results stay within the sensor range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !check_status) |-> (temperature_milli_c >= -18'sd45000
            && temperature_milli_c <= 18'sd130000 && humidity_milli_pct <= 17'd100000))
        else $error("converted value out of range");

    // a result can only appear once input has been offered
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !$past(push)) |=> empty || !$past(empty, 1) || $past(push, 2)
            || $past(push, 3) || $past(push, 4) || !$past(empty, 2) || !$past(empty, 3)
            || !$past(empty, 4) || !$past(full, 1) || !$past(full, 2))
        else $error("result appeared without input");

endmodule

bind humidity_temp_frame_decoder_top htfd_checker u_htfd_checker (.*);
